@@ rtl/vtdi_pkg.sv @@
package vtdi_pkg;

   // field widths
   localparam int IDX_WIDTH  = 16;
   localparam int SLOT_WIDTH = 16;
   localparam int KEY_WIDTH  = 3 * IDX_WIDTH;

   // function codes
   localparam logic FUNC_CORNER   = 1'b0;
   localparam logic FUNC_NEW_MESH = 1'b1;

   // one beat travelling down the row of table cells
   typedef struct packed {
      logic                  valid;
      logic                  func;
      logic [KEY_WIDTH-1:0]  key;
      logic                  hit;
      logic                  is_new;
      logic [SLOT_WIDTH-1:0] slot;
   } beat_type;

endpackage

@@ rtl/vtdi_req_if.sv @@
interface vtdi_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [15:0] pos_index;
   logic [15:0] tex_index;
   logic [15:0] norm_index;

   modport source (output valid, func, pos_index, tex_index, norm_index, input ready);
   modport sink   (input valid, func, pos_index, tex_index, norm_index, output ready);
endinterface

@@ rtl/vtdi_rsp_if.sv @@
interface vtdi_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] vertex_slot;
   logic        is_new;
   logic        table_full;

   modport source (output valid, vertex_slot, is_new, table_full, input ready);
   modport sink   (input valid, vertex_slot, is_new, table_full, output ready);
endinterface

@@ rtl/vtdi_cell.sv @@
module vtdi_cell #(
   parameter int SLOT_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  vtdi_pkg::beat_type beat_i,
   output vtdi_pkg::beat_type beat_o
);
   import vtdi_pkg::*;

   localparam logic [SLOT_WIDTH-1:0] MY_SLOT = SLOT_WIDTH'(SLOT_INDEX);

   logic [KEY_WIDTH-1:0] entry_ff, entry_in;
   logic                 used_ff, used_in;
   beat_type             beat_ff, beat_in;
   logic                 entry_match;

   // compare against the stored triple
   assign entry_match = used_ff && (entry_ff == beat_i.key);

   // clear on new mesh, claim on first match or first free cell
   always_comb begin
      beat_in  = beat_i;
      used_in  = used_ff;
      entry_in = entry_ff;
      if (beat_i.valid) begin
         if (beat_i.func == FUNC_NEW_MESH) begin
            used_in = 1'b0;
         end else if (!beat_i.hit) begin
            if (entry_match) begin
               beat_in.hit  = 1'b1;
               beat_in.slot = MY_SLOT;
            end else if (!used_ff) begin
               entry_in       = beat_i.key;
               used_in        = 1'b1;
               beat_in.hit    = 1'b1;
               beat_in.is_new = 1'b1;
               beat_in.slot   = MY_SLOT;
            end
         end
      end
   end

   // cell state and hand-off register
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         beat_ff.valid <= 1'b0;
      end else if (enable) begin
         used_ff  <= used_in;
         entry_ff <= entry_in;
         beat_ff  <= beat_in;
      end
   end

   assign beat_o = beat_ff;

endmodule

@@ rtl/vertex_triple_dedup_indexer_unit.sv @@
// channel  | direction | fields
// ---------+-----------+-----------------------------------------------
// req_bus  | in        | func, pos_index, tex_index, norm_index
// rsp_bus  | out       | vertex_slot, is_new, table_full
//
// one beat accepted per cycle while the response is not stalled; a corner
// passes the row of one cell per table slot, then the response register
// a new-mesh beat empties each cell as it passes and gives no response
// reset empties the table and drops beats in flight
// a stalled response freezes the whole row and holds req_bus.ready low
module vertex_triple_dedup_indexer_unit #(
   parameter int MAX_UNIQUE_VERTICES = 256
) (
   input logic     clock,
   input logic     reset,
   vtdi_req_if.sink   req_bus,
   vtdi_rsp_if.source rsp_bus
);
   import vtdi_pkg::*;

   beat_type              chain [0:MAX_UNIQUE_VERTICES];
   logic                  enable;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_WIDTH-1:0] rsp_slot_ff, rsp_slot_in;
   logic                  rsp_new_ff, rsp_new_in;
   logic                  rsp_full_ff, rsp_full_in;
   beat_type              last_beat;

   // the row moves whenever the response register is free
   assign enable      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = enable;

   // make indices 0-based and launch the beat
   always_comb begin
      chain[0].valid  = req_bus.valid;
      chain[0].func   = req_bus.func;
      chain[0].key    = {req_bus.pos_index - 16'd1,
                         req_bus.tex_index - 16'd1,
                         req_bus.norm_index - 16'd1};
      chain[0].hit    = 1'b0;
      chain[0].is_new = 1'b0;
      chain[0].slot   = '0;
   end

   // one cell per table slot
   for (genvar i = 0; i < MAX_UNIQUE_VERTICES; i++) begin : g_cell
      vtdi_cell #(
         .SLOT_INDEX (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .beat_i (chain[i]),
         .beat_o (chain[i+1])
      );
   end

   assign last_beat = chain[MAX_UNIQUE_VERTICES];

   // response for corner beats only
   always_comb begin
      rsp_valid_in = last_beat.valid && (last_beat.func == FUNC_CORNER);
      rsp_slot_in  = last_beat.hit ? last_beat.slot : '0;
      rsp_new_in   = last_beat.hit && last_beat.is_new;
      rsp_full_in  = !last_beat.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_slot_ff <= rsp_slot_in;
         rsp_new_ff  <= rsp_new_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.vertex_slot = rsp_slot_ff;
   assign rsp_bus.is_new      = rsp_new_ff;
   assign rsp_bus.table_full  = rsp_full_ff;

endmodule
